@@ hdl/dfpa_pkg.sv @@
// Shared types, codes and constant tables of the decimal fixed-point ALU.
// No dependencies; dfpa_regs, dfpa_ctrl, dfpa_dp and decimal_fixed_point_alu import this package.
package dfpa_pkg;

    localparam int VAL_W  = 64;
    localparam int WIDE_W = 128;
    localparam int CNT_W  = 8;
    localparam int ADDR_W = 3;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_NEG = 3'd4;
    localparam logic [2:0] OP_PCT = 3'd5;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIVZ = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    localparam logic [3:0] FRAC_RESET = 4'd10;
    localparam logic [ADDR_W-1:0] ADDR_FRAC = 3'd0;
    localparam logic [63:0] PCT_DIVISOR = 64'd100;

    typedef struct packed {
        logic load;
        logic conv;
        logic decode;
        logic mul_step;
        logic div_init;
        logic div_step;
        logic round;
        logic sat;
        logic dd_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       b_zero;
    } stat_t;

    function automatic logic [63:0] pow10(input logic [4:0] k);
        logic [63:0] p;
        case (k)
            5'd0:    p = 64'd1;
            5'd1:    p = 64'd10;
            5'd2:    p = 64'd100;
            5'd3:    p = 64'd1000;
            5'd4:    p = 64'd10000;
            5'd5:    p = 64'd100000;
            5'd6:    p = 64'd1000000;
            5'd7:    p = 64'd10000000;
            5'd8:    p = 64'd100000000;
            5'd9:    p = 64'd1000000000;
            5'd10:   p = 64'd10000000000;
            5'd11:   p = 64'd100000000000;
            5'd12:   p = 64'd1000000000000;
            5'd13:   p = 64'd10000000000000;
            5'd14:   p = 64'd100000000000000;
            5'd15:   p = 64'd1000000000000000;
            5'd16:   p = 64'd10000000000000000;
            default: p = 64'd0;
        endcase
        return p;
    endfunction

    function automatic logic [63:0] half_scale(input logic [3:0] k);
        logic [63:0] p;
        case (k)
            4'd0:    p = 64'd0;
            4'd1:    p = 64'd5;
            4'd2:    p = 64'd50;
            4'd3:    p = 64'd500;
            4'd4:    p = 64'd5000;
            4'd5:    p = 64'd50000;
            4'd6:    p = 64'd500000;
            4'd7:    p = 64'd5000000;
            4'd8:    p = 64'd50000000;
            4'd9:    p = 64'd500000000;
            4'd10:   p = 64'd5000000000;
            4'd11:   p = 64'd50000000000;
            4'd12:   p = 64'd500000000000;
            4'd13:   p = 64'd5000000000000;
            4'd14:   p = 64'd50000000000000;
            default: p = 64'd500000000000000;
        endcase
        return p;
    endfunction

endpackage

@@ hdl/dfpa_in_if.sv @@
// Operand channel: valid/ready handshake with the operation word.
// No dependencies.
interface dfpa_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  operation;
    logic        a_negative;
    logic [63:0] a_bcd;
    logic        b_negative;
    logic [63:0] b_bcd;

    modport source (output valid, operation, a_negative, a_bcd, b_negative, b_bcd,
                    input ready);
    modport sink (input valid, operation, a_negative, a_bcd, b_negative, b_bcd,
                  output ready);
endinterface

@@ hdl/dfpa_out_if.sv @@
// Result channel: valid/ready handshake with the result word.
// No dependencies.
interface dfpa_out_if;
    logic        valid;
    logic        ready;
    logic        result_negative;
    logic [63:0] result_bcd;
    logic [1:0]  status;

    modport source (output valid, result_negative, result_bcd, status, input ready);
    modport sink (input valid, result_negative, result_bcd, status, output ready);
endinterface

@@ hdl/dfpa_regs.sv @@
// APB configuration register file: holds frac_digits.
// Depends on dfpa_pkg.
module dfpa_regs
    import dfpa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output logic [3:0]        frac_digits
);

    logic [3:0] frac_reg;
    logic [3:0] frac_next;
    logic       hit;

    assign hit    = (paddr[ADDR_W-1] == ADDR_FRAC[ADDR_W-1]);
    assign pready = 1'b1;

    always_comb
    begin
        frac_next = frac_reg;
        if (psel && penable && pwrite && hit)
        begin
            frac_next = pwdata[3:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frac_reg <= FRAC_RESET;
        end
        else
        begin
            frac_reg <= frac_next;
        end
    end

    assign prdata      = hit ? {28'd0, frac_reg} : 32'd0;
    assign frac_digits = frac_reg;

endmodule

@@ hdl/dfpa_ctrl.sv @@
// Sequencer of the ALU: steps conversion, multiply, divide, round and BCD output.
// Depends on dfpa_pkg.
module dfpa_ctrl
    import dfpa_pkg::*;
#(
    parameter int DIGIT_CNT = 16
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    output logic  out_valid,
    input  logic  out_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CONV   = 4'd1;
    localparam logic [3:0] S_DECODE = 4'd2;
    localparam logic [3:0] S_MUL    = 4'd3;
    localparam logic [3:0] S_DIVI   = 4'd4;
    localparam logic [3:0] S_DIV    = 4'd5;
    localparam logic [3:0] S_ROUND  = 4'd6;
    localparam logic [3:0] S_SAT    = 4'd7;
    localparam logic [3:0] S_DD     = 4'd8;
    localparam logic [3:0] S_DONE   = 4'd9;

    localparam logic [CNT_W-1:0] CONV_LAST = CNT_W'(DIGIT_CNT - 1);
    localparam logic [CNT_W-1:0] MUL_LAST  = CNT_W'(VAL_W - 1);
    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(WIDE_W - 1);
    localparam logic [CNT_W-1:0] DD_LAST   = CNT_W'(VAL_W - 1);

    logic [3:0]       state_reg;
    logic [3:0]       state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             ovalid_reg;
    logic             ovalid_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CONV;
                    cnt_next   = '0;
                end
            end
            S_CONV:
            begin
                cmd.conv = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CONV_LAST)
                begin
                    state_next = S_DECODE;
                    cnt_next   = '0;
                end
            end
            S_DECODE:
            begin
                cmd.decode = 1'b1;
                if (stat.op == OP_MUL || (stat.op == OP_DIV && !stat.b_zero))
                begin
                    state_next = S_MUL;
                end
                else if (stat.op == OP_PCT)
                begin
                    state_next = S_DIVI;
                end
                else
                begin
                    state_next = S_SAT;
                end
            end
            S_MUL:
            begin
                cmd.mul_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == MUL_LAST)
                begin
                    state_next = S_DIVI;
                    cnt_next   = '0;
                end
            end
            S_DIVI:
            begin
                cmd.div_init = 1'b1;
                state_next   = S_DIV;
                cnt_next     = '0;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = S_ROUND;
                    cnt_next   = '0;
                end
            end
            S_ROUND:
            begin
                cmd.round  = 1'b1;
                state_next = S_SAT;
            end
            S_SAT:
            begin
                cmd.sat    = 1'b1;
                state_next = S_DD;
                cnt_next   = '0;
            end
            S_DD:
            begin
                cmd.dd_step = 1'b1;
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == DD_LAST)
                begin
                    state_next = S_DONE;
                    cnt_next   = '0;
                end
            end
            S_DONE:
            begin
                if (!ovalid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ovalid_next = ovalid_reg;
        if (cmd.out_load)
        begin
            ovalid_next = 1'b1;
        end
        else if (out_ready)
        begin
            ovalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ovalid_reg;

endmodule

@@ hdl/dfpa_dp.sv @@
// Datapath: BCD-to-binary, shift-add multiply, restoring divide, BCD output.
// Depends on dfpa_pkg; driven by dfpa_ctrl commands.
module dfpa_dp
    import dfpa_pkg::*;
#(
    parameter int DIGIT_CNT = 16
)
(
    input  logic        clk,
    input  cmd_t        cmd,
    output stat_t       stat,
    input  logic [3:0]  frac_digits,
    input  logic [2:0]  operation,
    input  logic        a_negative,
    input  logic [63:0] a_bcd,
    input  logic        b_negative,
    input  logic [63:0] b_bcd,
    output logic        result_negative,
    output logic [63:0] result_bcd,
    output logic [1:0]  status
);

    localparam int BCD_W = 4 * DIGIT_CNT;
    localparam logic [VAL_W-1:0] MAXV = pow10(5'(DIGIT_CNT)) - 64'd1;

    logic [2:0]        op_reg;
    logic              an_reg, bn_reg;
    logic [BCD_W-1:0]  sa_reg, sb_reg;
    logic [VAL_W-1:0]  va_reg, vb_reg;
    logic [WIDE_W-1:0] acc_reg, mcand_reg, num_reg;
    logic [VAL_W-1:0]  mplier_reg, rem_reg, dvsr_reg, binv_reg;
    logic              neg_reg;
    logic [1:0]        st_reg;
    logic [BCD_W-1:0]  bcd_reg, bcd_adj;
    logic              rneg_reg;
    logic [63:0]       rbcd_reg;
    logic [1:0]        rst_reg;

    logic [VAL_W-1:0]  scale;
    logic              bn_eff;
    logic [VAL_W:0]    trial;
    logic              ge;
    logic [VAL_W-1:0]  sat_val;
    logic [WIDE_W-1:0] dec_num;
    logic              dec_neg;
    logic [1:0]        dec_st;

    assign scale  = pow10({1'b0, frac_digits});
    assign bn_eff = bn_reg ^ (op_reg == OP_SUB);
    assign trial  = {rem_reg, num_reg[WIDE_W-1]};
    assign ge     = (trial >= {1'b0, dvsr_reg});
    assign sat_val = (num_reg > {64'd0, MAXV}) ? MAXV : num_reg[VAL_W-1:0];

    always_comb
    begin
        for (int i = 0; i < DIGIT_CNT; i++)
        begin
            bcd_adj[4*i +: 4] = (bcd_reg[4*i +: 4] >= 4'd5) ?
                                bcd_reg[4*i +: 4] + 4'd3 : bcd_reg[4*i +: 4];
        end
    end

    always_comb
    begin
        dec_num = '0;
        dec_neg = 1'b0;
        dec_st  = ST_OK;
        case (op_reg) inside
            OP_ADD, OP_SUB:
            begin
                if (an_reg == bn_eff)
                begin
                    dec_num = {64'd0, va_reg} + {64'd0, vb_reg};
                    dec_neg = an_reg;
                end
                else if (va_reg >= vb_reg)
                begin
                    dec_num = {64'd0, va_reg - vb_reg};
                    dec_neg = an_reg;
                end
                else
                begin
                    dec_num = {64'd0, vb_reg - va_reg};
                    dec_neg = bn_eff;
                end
            end
            OP_MUL:
            begin
                dec_neg = an_reg ^ bn_reg;
            end
            OP_DIV:
            begin
                if (vb_reg == '0)
                begin
                    dec_st = ST_DIVZ;
                end
                else
                begin
                    dec_neg = an_reg ^ bn_reg;
                end
            end
            OP_NEG:
            begin
                dec_num = {64'd0, va_reg};
                dec_neg = !an_reg;
            end
            OP_PCT:
            begin
                dec_neg = an_reg;
            end
            default:
            begin
                dec_neg = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= operation;
            an_reg <= a_negative;
            bn_reg <= b_negative;
            sa_reg <= a_bcd[BCD_W-1:0];
            sb_reg <= b_bcd[BCD_W-1:0];
            va_reg <= '0;
            vb_reg <= '0;
        end
        if (cmd.conv)
        begin
            va_reg <= (va_reg << 3) + (va_reg << 1) + VAL_W'(sa_reg[BCD_W-1 -: 4]);
            vb_reg <= (vb_reg << 3) + (vb_reg << 1) + VAL_W'(sb_reg[BCD_W-1 -: 4]);
            sa_reg <= sa_reg << 4;
            sb_reg <= sb_reg << 4;
        end
        if (cmd.decode)
        begin
            st_reg     <= dec_st;
            acc_reg    <= '0;
            mcand_reg  <= {64'd0, va_reg};
            mplier_reg <= (op_reg == OP_DIV) ? scale : vb_reg;
            num_reg    <= dec_num;
            neg_reg    <= dec_neg;
        end
        if (cmd.mul_step)
        begin
            if (mplier_reg[0])
            begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg  <= mcand_reg << 1;
            mplier_reg <= mplier_reg >> 1;
        end
        if (cmd.div_init)
        begin
            rem_reg <= '0;
            case (op_reg)
                OP_MUL:
                begin
                    num_reg  <= acc_reg + {64'd0, half_scale(frac_digits)};
                    dvsr_reg <= scale;
                end
                OP_PCT:
                begin
                    num_reg  <= {64'd0, va_reg};
                    dvsr_reg <= PCT_DIVISOR;
                end
                default:
                begin
                    num_reg  <= acc_reg;
                    dvsr_reg <= vb_reg;
                end
            endcase
        end
        if (cmd.div_step)
        begin
            rem_reg <= ge ? VAL_W'(trial - {1'b0, dvsr_reg}) : trial[VAL_W-1:0];
            num_reg <= {num_reg[WIDE_W-2:0], ge};
        end
        if (cmd.round)
        begin
            if (op_reg != OP_MUL && ({rem_reg, 1'b0} >= {1'b0, dvsr_reg})
                && rem_reg != '0)
            begin
                num_reg <= num_reg + 128'd1;
            end
        end
        if (cmd.sat)
        begin
            binv_reg <= sat_val;
            bcd_reg  <= '0;
            neg_reg  <= neg_reg && (sat_val != '0);
            if (num_reg > {64'd0, MAXV})
            begin
                st_reg <= ST_OVF;
            end
        end
        if (cmd.dd_step)
        begin
            bcd_reg  <= {bcd_adj[BCD_W-2:0], binv_reg[VAL_W-1]};
            binv_reg <= binv_reg << 1;
        end
        if (cmd.out_load)
        begin
            rneg_reg <= neg_reg;
            rbcd_reg <= 64'(bcd_reg);
            rst_reg  <= st_reg;
        end
    end

    assign stat.op          = op_reg;
    assign stat.b_zero      = (vb_reg == '0);
    assign result_negative  = rneg_reg;
    assign result_bcd       = rbcd_reg;
    assign status           = rst_reg;

endmodule

@@ hdl/decimal_fixed_point_alu.sv @@
// Decimal fixed-point ALU: one operand word in, one result word out, one word in
// flight at a time. Each word is converted from BCD to binary, and the result back
// to BCD; multiply runs the one-bit-per-cycle shift-add multiplier and then the
// 128-bit restoring divider, divide the same when the divisor is nonzero, percent
// only the divider; add, subtract and negate skip both units. A finished word
// waits in the output register while the next operand is taken.
// Depends on dfpa_pkg, dfpa_in_if, dfpa_out_if, dfpa_regs, dfpa_ctrl, dfpa_dp.
module decimal_fixed_point_alu
    import dfpa_pkg::*;
#(
    parameter int DIGIT_CNT = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    dfpa_in_if.sink           operand,
    dfpa_out_if.source        result
);

    logic [3:0] frac_digits;
    cmd_t       cmd;
    stat_t      stat;

    dfpa_regs u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .frac_digits (frac_digits)
    );

    dfpa_ctrl #(.DIGIT_CNT(DIGIT_CNT)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (operand.valid),
        .in_ready  (operand.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    dfpa_dp #(.DIGIT_CNT(DIGIT_CNT)) u_dp (
        .clk             (clk),
        .cmd             (cmd),
        .stat            (stat),
        .frac_digits     (frac_digits),
        .operation       (operand.operation),
        .a_negative      (operand.a_negative),
        .a_bcd           (operand.a_bcd),
        .b_negative      (operand.b_negative),
        .b_bcd           (operand.b_bcd),
        .result_negative (result.result_negative),
        .result_bcd      (result.result_bcd),
        .status          (result.status)
    );

endmodule
